// ----- sv/ptrs_pkg.sv -----
`default_nettype none
package ptrs_pkg;

    localparam int IVL_W  = 23;
    localparam int DUR_W  = 23;
    localparam int CUR_W  = 15;
    localparam int CFG_W  = 23;
    localparam int TIME_W = 64;
    localparam int SPAN_W = 33;
    localparam int PROD_W = CUR_W + SPAN_W;
    localparam int Q_W    = CUR_W;
    localparam int MS_US  = 1000;

    localparam logic [TIME_W-1:0] HOLD_US = 64'd200000;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_DURATION = 2'd1;
    localparam logic [1:0] CFG_CURRENT  = 2'd2;

    localparam logic [IVL_W-1:0] INTERVAL_RST = 23'd30000;
    localparam logic [DUR_W-1:0] DURATION_RST = 23'd1000;
    localparam logic [CUR_W-1:0] CURRENT_RST  = 15'd2000;

    typedef struct packed {
        logic capture;
        logic prep;
        logic eval;
        logic div_start;
        logic commit;
    } ptrs_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ptrs_sts_t;

endpackage
`default_nettype wire

// ----- sv/ptrs_div.sv -----
`default_nettype none
module ptrs_div
    import ptrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [SPAN_W-1:0] divisor,
    output logic                   done,
    output logic [Q_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [SPAN_W-1:0] rem_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              fits;
    logic [SPAN_W-1:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[Q_W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = trial >= {1'b0, divisor};
        rem_step = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNT_W'(1);
            done_reg <= cnt_reg == CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:Q_W];
            quo_reg <= dividend[Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- sv/ptrs_ctrl.sv -----
`default_nettype none
module ptrs_ctrl
    import ptrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire ptrs_sts_t  sts,
    output ptrs_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.need_div ? ST_DSTART : ST_COMMIT;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- sv/ptrs_dp.sv -----
`default_nettype none
module ptrs_dp
    import ptrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [1:0]        kind,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire logic              move_permitted,
    input  wire logic              cmd_ready,
    input  wire logic              current_valid,
    input  wire logic signed [15:0] measured_current_ma,
    input  wire ptrs_cmd_t         cmd,
    output ptrs_sts_t              sts,
    output logic                   apply_idle_stop,
    output logic                   start_compress,
    output logic                   send_torque,
    output logic [CUR_W-1:0]       torque_target_ma,
    output logic                   release_res,
    output logic                   done_by_time,
    output logic                   done_by_current,
    output logic                   compressing
);

    logic [IVL_W-1:0]  interval_reg;
    logic [DUR_W-1:0]  duration_reg;
    logic [CUR_W-1:0]  current_reg;

    logic              mode_reg;
    logic              pending_reg;
    logic              sent_reg;
    logic [TIME_W-1:0] last_comp_reg;
    logic [TIME_W-1:0] start_time_reg;
    logic [TIME_W-1:0] last_cmd_reg;

    logic [1:0]        kind_reg;
    logic [TIME_W-1:0] now_reg;
    logic              permitted_reg;
    logic              ready_reg;
    logic              cur_valid_reg;
    logic [15:0]       meas_reg;

    logic [TIME_W-1:0] dcomp_reg;
    logic [TIME_W-1:0] delapsed_reg;
    logic [TIME_W-1:0] dcmd_reg;
    logic [SPAN_W-1:0] ivl_reg;
    logic [SPAN_W-1:0] span_reg;

    logic              idle_ok_reg;
    logic              by_time_reg;
    logic              send_reg;
    logic              by_cur_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              o_stop_reg;
    logic              o_start_reg;
    logic              o_send_reg;
    logic [CUR_W-1:0]  o_target_reg;
    logic              o_release_reg;
    logic              o_by_time_reg;
    logic              o_by_cur_reg;
    logic              o_comp_reg;

    logic [16:0]       mag;
    logic [19:0]       cur10;
    logic [19:0]       tgt9;
    logic              time_cmp;
    logic              send_cmp;
    logic              div_done;
    logic [Q_W-1:0]    quotient;
    logic [CUR_W-1:0]  target;

    always_comb
    begin
        mag      = meas_reg[15] ? (17'd0 - {1'b1, meas_reg}) : {1'b0, meas_reg};
        cur10    = 20'({mag, 3'b000}) + 20'({mag, 1'b0});
        tgt9     = 20'({current_reg, 3'b000}) + 20'(current_reg);
        time_cmp = delapsed_reg >= TIME_W'(span_reg);
        send_cmp = !sent_reg || (dcmd_reg > HOLD_US);
        target   = by_time_reg ? current_reg : quotient;
    end

    assign sts.need_div = mode_reg && (kind_reg == KIND_TICK) && !time_cmp && send_cmp;
    assign sts.div_done = div_done;

    ptrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            duration_reg <= DURATION_RST;
            current_reg  <= CURRENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data[IVL_W-1:0];
                CFG_DURATION: duration_reg <= cfg_data[DUR_W-1:0];
                CFG_CURRENT:  current_reg  <= cfg_data[CUR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            now_reg       <= now_us;
            permitted_reg <= move_permitted;
            ready_reg     <= cmd_ready;
            cur_valid_reg <= current_valid;
            meas_reg      <= measured_current_ma;
        end
        if (cmd.prep)
        begin
            dcomp_reg    <= now_reg - last_comp_reg;
            delapsed_reg <= now_reg - start_time_reg;
            dcmd_reg     <= now_reg - last_cmd_reg;
            ivl_reg      <= SPAN_W'(interval_reg) * SPAN_W'(MS_US);
            span_reg     <= SPAN_W'(duration_reg) * SPAN_W'(MS_US);
        end
        if (cmd.eval)
        begin
            idle_ok_reg <= dcomp_reg >= TIME_W'(ivl_reg);
            by_time_reg <= time_cmp;
            send_reg    <= send_cmp;
            by_cur_reg  <= cur_valid_reg && (delapsed_reg > HOLD_US) && (cur10 >= tgt9);
            prod_reg    <= PROD_W'(current_reg) * PROD_W'(delapsed_reg[SPAN_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            sent_reg       <= 1'b0;
            last_comp_reg  <= '0;
            start_time_reg <= '0;
            last_cmd_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (kind_reg)
                KIND_BEGIN:
                begin
                    mode_reg      <= 1'b0;
                    pending_reg   <= 1'b1;
                    sent_reg      <= 1'b0;
                    last_comp_reg <= now_reg;
                    last_cmd_reg  <= now_reg;
                end
                KIND_RESET:
                begin
                    mode_reg    <= 1'b0;
                    pending_reg <= 1'b1;
                    sent_reg    <= 1'b0;
                end
                KIND_TICK:
                begin
                    pending_reg <= 1'b0;
                    if (!mode_reg)
                    begin
                        if (idle_ok_reg && permitted_reg)
                        begin
                            mode_reg       <= 1'b1;
                            start_time_reg <= now_reg;
                            last_cmd_reg   <= now_reg;
                            sent_reg       <= 1'b0;
                        end
                    end
                    else if (by_time_reg || by_cur_reg)
                    begin
                        mode_reg      <= 1'b0;
                        sent_reg      <= 1'b0;
                        last_comp_reg <= now_reg;
                        last_cmd_reg  <= now_reg;
                    end
                    else if (send_reg && ready_reg)
                    begin
                        sent_reg     <= 1'b1;
                        last_cmd_reg <= now_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_stop_reg    <= 1'b0;
            o_start_reg   <= 1'b0;
            o_send_reg    <= 1'b0;
            o_target_reg  <= '0;
            o_release_reg <= 1'b0;
            o_by_time_reg <= 1'b0;
            o_by_cur_reg  <= 1'b0;
            o_comp_reg    <= mode_reg;
            unique case (kind_reg)
                KIND_BEGIN, KIND_RESET:
                begin
                    o_comp_reg <= 1'b0;
                end
                KIND_TICK:
                begin
                    o_stop_reg <= pending_reg;
                    if (!mode_reg)
                    begin
                        o_start_reg <= idle_ok_reg && permitted_reg;
                        o_comp_reg  <= idle_ok_reg && permitted_reg;
                    end
                    else
                    begin
                        if (send_reg)
                        begin
                            o_send_reg   <= 1'b1;
                            o_target_reg <= target;
                        end
                        if (by_time_reg || by_cur_reg)
                        begin
                            o_release_reg <= 1'b1;
                            o_by_time_reg <= by_time_reg;
                            o_by_cur_reg  <= by_cur_reg;
                            o_comp_reg    <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign apply_idle_stop  = o_stop_reg;
    assign start_compress   = o_start_reg;
    assign send_torque      = o_send_reg;
    assign torque_target_ma = o_target_reg;
    assign release_res      = o_release_reg;
    assign done_by_time     = o_by_time_reg;
    assign done_by_current  = o_by_cur_reg;
    assign compressing      = o_comp_reg;

endmodule
`default_nettype wire

// ----- sv/periodic_torque_ramp_sequencer.sv -----
// Channel   Handshake            Payload
// in        in_valid / in_stall  kind, now_us, move_permitted, cmd_ready,
//                                current_valid, measured_current_ma
// out       out_valid/out_stall  apply_idle_stop .. compressing, one per input
// cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// An item passes capture, prep, eval and commit, with a divider start and wait
// when the 15-step restoring divider forms the ramp target current * elapsed / span.
// rst_n resets sequencer state, timers and config defaults, but not data registers.
// A finished result sits in the output register; the next transfer is taken
// meanwhile but its result waits until the previous one has been taken.
`default_nettype none
module periodic_torque_ramp_sequencer
    import ptrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        kind,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire logic              move_permitted,
    input  wire logic              cmd_ready,
    input  wire logic              current_valid,
    input  wire logic signed [15:0] measured_current_ma,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   apply_idle_stop,
    output logic                   start_compress,
    output logic                   send_torque,
    output logic [CUR_W-1:0]       torque_target_ma,
    output logic                   release_res,
    output logic                   done_by_time,
    output logic                   done_by_current,
    output logic                   compressing
);

    ptrs_cmd_t cmd;
    ptrs_sts_t sts;

    ptrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptrs_dp u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .kind                (kind),
        .now_us              (now_us),
        .move_permitted      (move_permitted),
        .cmd_ready           (cmd_ready),
        .current_valid       (current_valid),
        .measured_current_ma (measured_current_ma),
        .cmd                 (cmd),
        .sts                 (sts),
        .apply_idle_stop     (apply_idle_stop),
        .start_compress      (start_compress),
        .send_torque         (send_torque),
        .torque_target_ma    (torque_target_ma),
        .release_res         (release_res),
        .done_by_time        (done_by_time),
        .done_by_current     (done_by_current),
        .compressing         (compressing)
    );

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transfer is in progress");

    a_target_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_torque) |-> (torque_target_ma == '0))
        else $error("torque target without send");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (done_by_time || done_by_current)) |-> (release_res && !compressing))
        else $error("done flag without release");

    a_start_compresses: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_compress) |-> (compressing && !release_res))
        else $error("start without compressing");

endmodule
`default_nettype wire
